[rtl/core/heap_path_lister_and_checker_defines.svh]
// Assertion macros shared by the heap path lister and checker RTL.
// Each macro expands to one labeled concurrent assertion, disabled in reset.
`ifndef HEAP_PATH_LISTER_AND_CHECKER_DEFINES_SVH
`define HEAP_PATH_LISTER_AND_CHECKER_DEFINES_SVH

// Same-cycle implication.
`define HPLC_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hplc check failed");

// Next-cycle implication.
`define HPLC_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hplc check failed");

`endif

[rtl/core/hplc_pkg.sv]
// ----------------------------------------------------------------------------
// hplc_pkg
// Sizes, codes, types and tree-index helpers for the heap path lister.
// ----------------------------------------------------------------------------
package hplc_pkg;

  localparam int MAX_NODES  = 1024;
  localparam int KEY_W      = 32;
  localparam int CFG_W      = 11;
  localparam int PATH_KEY_W = 32;
  localparam int IDX_W      = $clog2(MAX_NODES + 1);
  localparam int ADDR_W     = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int LVL_W      = (IDX_W > 1) ? $clog2(IDX_W) : 1;

  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_FETCH = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  localparam logic [1:0] VERDICT_NONE = 2'd0;
  localparam logic [1:0] VERDICT_MAX  = 2'd1;
  localparam logic [1:0] VERDICT_MIN  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_FETCH
  } state_t;

  typedef struct packed {
    logic             restart;
    logic             advance;
    logic [IDX_W-1:0] restart_n;
  } walk_ctrl_t;

  typedef struct packed {
    logic [IDX_W-1:0] node;
    logic             end_path;
    logic             last;
  } walk_t;

  // Floor of log2; zero for zero and one.
  function automatic logic [LVL_W-1:0] level_of(input logic [IDX_W-1:0] x);
    logic [LVL_W-1:0] lv;
    lv = '0;
    for (int i = 0; i < IDX_W; i++) begin
      if (x[i]) begin
        lv = LVL_W'(i);
      end
    end
    return lv;
  endfunction

  // Clamp the programmed count into 1..MAX_NODES.
  function automatic logic [IDX_W-1:0] eff_n(input logic [CFG_W-1:0] v);
    if (v == '0) begin
      return IDX_W'(1);
    end
    if (32'(v) > 32'(MAX_NODES)) begin
      return IDX_W'(MAX_NODES);
    end
    return IDX_W'(v);
  endfunction

  // Rightmost leaf of the tree: end of the next-to-last level or the last node.
  function automatic logic [IDX_W-1:0] first_leaf(input logic [IDX_W-1:0] n);
    logic [IDX_W-1:0] top;
    top = (IDX_W'(1) << level_of(n)) - IDX_W'(1);
    return (top > (n >> 1)) ? top : n;
  endfunction

endpackage

[rtl/core/hplc_if.sv]
// ----------------------------------------------------------------------------
// hplc_in_if / hplc_out_if
// Valid/ready channels for command items and path result items.
// ----------------------------------------------------------------------------
interface hplc_in_if import hplc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       mode;
  logic [KEY_W-1:0] key;

  modport source (output valid, output mode, output key, input ready);
  modport sink (input valid, input mode, input key, output ready);
endinterface

interface hplc_out_if import hplc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [PATH_KEY_W-1:0] path_key;
  logic [CFG_W-1:0]      node_index;
  logic                  end_of_path;
  logic                  last_of_all;
  logic [1:0]            verdict;

  modport source (output valid, output path_key, output node_index, output end_of_path,
                  output last_of_all, output verdict, input ready);
  modport sink (input valid, input path_key, input node_index, input end_of_path,
                input last_of_all, input verdict, output ready);
endinterface

[rtl/core/hplc_ram.sv]
// ----------------------------------------------------------------------------
// hplc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hplc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/hplc_walk.sv]
// ----------------------------------------------------------------------------
// hplc_walk
// Root-to-leaf path sequencer: current leaf, step along its path, successor.
// ----------------------------------------------------------------------------
module hplc_walk import hplc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [IDX_W-1:0] n,
  input  walk_ctrl_t       ctrl,
  output walk_t            walk
);

  logic [IDX_W-1:0] current_leaf, current_leaf_next;
  logic [LVL_W-1:0] path_step, path_step_next;

  logic             bad_leaf;
  logic [IDX_W-1:0] lf;
  logic [LVL_W-1:0] lv;
  logic [LVL_W-1:0] st;
  logic [IDX_W-1:0] base;
  logic [IDX_W-1:0] succ;

  always_comb begin
    // Fall back to the first leaf if the held leaf is not a leaf of this tree.
    bad_leaf = (current_leaf == '0) || (current_leaf > n) || (current_leaf <= (n >> 1));
    lf       = bad_leaf ? first_leaf(n) : current_leaf;
    lv       = level_of(lf);
    st       = bad_leaf ? '0 : path_step;
    if (st > lv) begin
      st = '0;
    end
    base          = IDX_W'(1) << level_of(n);
    walk.node     = lf >> (lv - st);
    walk.end_path = (st == lv);
    walk.last     = walk.end_path && (lf == base);

    // Next leaf to the left, wrapping from the next-to-last level down to the last node.
    if (lf >= base) begin
      succ = lf - IDX_W'(1);
    end else if ((lf - IDX_W'(1)) > (n >> 1)) begin
      succ = lf - IDX_W'(1);
    end else begin
      succ = n;
    end

    current_leaf_next = current_leaf;
    path_step_next    = path_step;
    if (ctrl.restart) begin
      current_leaf_next = first_leaf(ctrl.restart_n);
      path_step_next    = '0;
    end else if (ctrl.advance) begin
      if (!walk.end_path) begin
        current_leaf_next = lf;
        path_step_next    = st + LVL_W'(1);
      end else if (walk.last) begin
        current_leaf_next = first_leaf(n);
        path_step_next    = '0;
      end else begin
        current_leaf_next = succ;
        path_step_next    = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_leaf <= first_leaf(IDX_W'(1));
      path_step    <= '0;
    end else begin
      current_leaf <= current_leaf_next;
      path_step    <= path_step_next;
    end
  end

endmodule

[rtl/core/heap_path_lister_and_checker.sv]
// ----------------------------------------------------------------------------
// heap_path_lister_and_checker
// Loads a level-order binary tree, checks max/min heap order against each
// parent, and lists the root-to-leaf paths right subtree first with a verdict.
// ----------------------------------------------------------------------------
//
//   channel   dir   handshake       payload
//   in_ch     in    valid/ready     mode, key
//   out_ch    out   valid/ready     path_key, node_index, end_of_path,
//                                   last_of_all, verdict
//   cfg       in    cfg_we          cfg_wdata (node_count)
//
// A stored load and a fetch each pass through a second state (ST_LOAD or
// ST_FETCH): the key RAM's registered read port gives the parent key (load)
// or path node key (fetch) in the cycle after the transfer. Clear, a load
// dropped on a full tree and the unused mode complete in idle. A fetch holds in
// ST_FETCH while the output register still holds an untaken result.
// Synchronous reset; the key RAM is not cleared and needs no sweep.
`include "heap_path_lister_and_checker_defines.svh"

module heap_path_lister_and_checker import hplc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CFG_W-1:0]  cfg_wdata,
  hplc_in_if.sink           in_ch,
  hplc_out_if.source        out_ch
);

  state_t state, state_next;

  logic [CFG_W-1:0] node_count;
  logic [IDX_W-1:0] load_count;
  logic             max_ok;
  logic             min_ok;
  logic [KEY_W-1:0] key_q;
  logic [IDX_W-1:0] idx_q;

  logic                  out_valid;
  logic [PATH_KEY_W-1:0] out_key;
  logic [CFG_W-1:0]      out_index;
  logic                  out_end;
  logic                  out_last;
  logic [1:0]            out_verdict;

  logic [IDX_W-1:0] n;
  logic [IDX_W-1:0] idx_new;
  logic             load_ok;
  logic             in_acc;
  logic             out_free;
  logic             clr_acc;
  logic             load_start;
  logic             fetch_done;
  logic             in_ready;

  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [KEY_W-1:0]  rd_data;
  logic              c_gt;
  logic              c_lt;
  logic [1:0]        verdict_now;

  walk_ctrl_t walk_ctrl;
  walk_t      walk;

  assign n        = eff_n(node_count);
  assign idx_new  = load_count + IDX_W'(1);
  assign load_ok  = (load_count < n);
  assign in_acc   = in_ch.valid && in_ready;
  assign out_free = !out_valid || out_ch.ready;

  // Shared key RAM: read parent or path node, write the new key on load.
  hplc_ram #(
    .WIDTH (KEY_W),
    .DEPTH (MAX_NODES)
  ) u_keys (
    .clk   (clk),
    .we    (state == ST_LOAD),
    .waddr (ADDR_W'(idx_q - IDX_W'(1))),
    .wdata (key_q),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  hplc_walk u_walk (
    .clk  (clk),
    .rst  (rst),
    .n    (n),
    .ctrl (walk_ctrl),
    .walk (walk)
  );

  // Heap-order compare of the new key against its parent.
  assign c_gt = $signed(key_q) > $signed(rd_data);
  assign c_lt = $signed(key_q) < $signed(rd_data);

  always_comb begin
    if (n == IDX_W'(1)) begin
      verdict_now = VERDICT_MAX;
    end else if (min_ok) begin
      verdict_now = VERDICT_MIN;
    end else if (max_ok) begin
      verdict_now = VERDICT_MAX;
    end else begin
      verdict_now = VERDICT_NONE;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_ch.mode)
            MODE_LOAD: begin
              if (load_ok) begin
                state_next = ST_LOAD;
              end
            end
            MODE_FETCH: state_next = ST_FETCH;
            default:    state_next = ST_IDLE;
          endcase
        end
      end
      ST_LOAD:  state_next = ST_IDLE;
      ST_FETCH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    in_ready   = (state == ST_IDLE);
    load_start = 1'b0;
    clr_acc    = 1'b0;
    rd_en      = 1'b0;
    fetch_done = (state == ST_FETCH) && out_free;
    rd_addr    = ADDR_W'(walk.node - IDX_W'(1));
    if (state == ST_IDLE && in_ch.valid) begin
      case (in_ch.mode)
        MODE_LOAD: begin
          load_start = load_ok;
          rd_en      = load_ok;
          rd_addr    = ADDR_W'((idx_new >> 1) - IDX_W'(1));
        end
        MODE_FETCH: rd_en   = 1'b1;
        MODE_CLEAR: clr_acc = 1'b1;
        default:    rd_en   = 1'b0;
      endcase
    end
    walk_ctrl.restart   = cfg_we || clr_acc;
    walk_ctrl.advance   = fetch_done;
    walk_ctrl.restart_n = cfg_we ? eff_n(cfg_wdata) : n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      node_count <= CFG_W'(1);
      load_count <= '0;
      max_ok     <= 1'b1;
      min_ok     <= 1'b1;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        node_count <= cfg_wdata;
      end
      if (clr_acc) begin
        load_count <= '0;
        max_ok     <= 1'b1;
        min_ok     <= 1'b1;
      end else if (state == ST_LOAD) begin
        load_count <= idx_q;
        // Root has no parent: skip the compare.
        if (idx_q > IDX_W'(1)) begin
          if (c_gt) begin
            max_ok <= 1'b0;
          end
          if (c_lt) begin
            min_ok <= 1'b0;
          end
        end
      end
      if (fetch_done) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers: hold the load item and the result.
  always_ff @(posedge clk) begin
    if (load_start) begin
      key_q <= in_ch.key;
      idx_q <= idx_new;
    end
    if (fetch_done) begin
      out_key     <= PATH_KEY_W'(rd_data);
      out_index   <= CFG_W'(walk.node);
      out_end     <= walk.end_path;
      out_last    <= walk.last;
      out_verdict <= walk.last ? verdict_now : VERDICT_NONE;
    end
  end

  assign in_ch.ready        = in_ready;
  assign out_ch.valid       = out_valid;
  assign out_ch.path_key    = out_key;
  assign out_ch.node_index  = out_index;
  assign out_ch.end_of_path = out_end;
  assign out_ch.last_of_all = out_last;
  assign out_ch.verdict     = out_verdict;

  // A fetch whose result slot is free lands in the output register next cycle.
  `HPLC_ASSERT_NXT(a_fetch_lands, clk, rst, fetch_done, out_ch.valid && state == ST_IDLE)
  // The final element of the listing always ends a path.
  `HPLC_ASSERT_IMP(a_last_ends, clk, rst, out_ch.valid && out_ch.last_of_all, out_ch.end_of_path)
  // A load step commits its index as the new load count.
  `HPLC_ASSERT_NXT(a_load_count, clk, rst, state == ST_LOAD, load_count == $past(idx_q))
  // Heap flags only come back through clear or reset.
  `HPLC_ASSERT_IMP(a_flag_rise, clk, rst, $rose(max_ok) || $rose(min_ok), $past(clr_acc) || $past(rst))

endmodule
